// File: hw/rtl/ipv6dac_pkg.sv
`default_nettype none

package ipv6dac_pkg;

    // Preference codes on the result port.
    localparam logic [1:0] PREF_A     = 2'd0;
    localparam logic [1:0] PREF_EQUAL = 2'd1;
    localparam logic [1:0] PREF_B     = 2'd2;

    // Bit positions within a flags field.
    localparam int FLAG_PRESENT    = 0;
    localparam int FLAG_DEPRECATED = 1;
    localparam int FLAG_HOME       = 2;

    localparam logic [63:0] LINK_LOCAL_HIGH = 64'hfe80_0000_0000_0000;
    localparam logic [7:0]  MAP_PREC_RESET  = 8'd35;

    typedef struct packed {
        logic [5:0] prec;
        logic [3:0] label;
        logic       mapped;
    } t_policy;

    // Everything the first stage hands to the second.
    typedef struct packed {
        logic         match_a;
        logic         match_b;
        logic         link_da;
        logic         link_db;
        logic [2:0]   flags_a;
        logic [2:0]   flags_b;
        t_policy      pol_da;
        t_policy      pol_db;
        t_policy      pol_sa;
        t_policy      pol_sb;
        logic [127:0] diff_a;
        logic [127:0] diff_b;
    } t_s1;

    // Everything the second stage hands to the rule chain.
    typedef struct packed {
        logic       match_a;
        logic       match_b;
        logic       link_da;
        logic       link_db;
        logic [2:0] flags_a;
        logic [2:0] flags_b;
        logic       label_eq_a;
        logic       label_eq_b;
        logic [7:0] prec_a;
        logic [7:0] prec_b;
        logic       mapped_a;
        logic       mapped_b;
        logic [7:0] cp_a;
        logic [7:0] cp_b;
    } t_s2;

    // Default policy table, longest prefix first so the first hit is the longest one.
    function automatic t_policy classify(input logic [63:0] hi, input logic [63:0] lo);
        t_policy p;
        if (hi == 64'd0 && lo == 64'd1) begin
            p = '{prec: 6'd50, label: 4'd0, mapped: 1'b0};
        end else if (hi == 64'd0 && lo[63:32] == 32'h0000_ffff) begin
            p = '{prec: 6'd0, label: 4'd4, mapped: 1'b1};
        end else if (hi == 64'd0 && lo[63:32] == 32'h0000_0000) begin
            p = '{prec: 6'd1, label: 4'd3, mapped: 1'b0};
        end else if (hi[63:32] == 32'h2001_0000) begin
            p = '{prec: 6'd5, label: 4'd5, mapped: 1'b0};
        end else if (hi[63:48] == 16'h2002) begin
            p = '{prec: 6'd30, label: 4'd2, mapped: 1'b0};
        end else if (hi[63:48] == 16'h3ffe) begin
            p = '{prec: 6'd1, label: 4'd12, mapped: 1'b0};
        end else if (hi[63:54] == 10'b11_1111_1011) begin
            p = '{prec: 6'd1, label: 4'd11, mapped: 1'b0};
        end else if (hi[63:57] == 7'b111_1110) begin
            p = '{prec: 6'd3, label: 4'd13, mapped: 1'b0};
        end else begin
            p = '{prec: 6'd40, label: 4'd1, mapped: 1'b0};
        end
        return p;
    endfunction

    // Leading zero count of a 128-bit word by seven halving steps; all zeros gives 128.
    function automatic logic [7:0] lzc128(input logic [127:0] x);
        logic [127:0] v;
        logic [6:0]   n;
        v = x;
        n = 7'd0;
        for (int k = 6; k >= 0; k--) begin
            if ((v >> (128 - (1 << k))) == '0) begin
                n = n | 7'(1 << k);
                v = v << (1 << k);
            end
        end
        return (x == '0) ? 8'd128 : {1'b0, n};
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/ipv6dac_front.sv
`default_nettype none

module ipv6dac_front
    import ipv6dac_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic [63:0] i_dest_a_high,
    input  wire logic [63:0] i_dest_a_low,
    input  wire logic [63:0] i_src_a_high,
    input  wire logic [63:0] i_src_a_low,
    input  wire logic [2:0]  i_flags_a,
    input  wire logic [63:0] i_dest_b_high,
    input  wire logic [63:0] i_dest_b_low,
    input  wire logic [63:0] i_src_b_high,
    input  wire logic [63:0] i_src_b_low,
    input  wire logic [2:0]  i_flags_b,
    output logic             o_valid,
    output t_s1              o_s1
);

    logic r_valid;
    t_s1  r_s1;
    t_s1  n_s1;

    always_comb begin
        n_s1.link_da = (i_dest_a_high == LINK_LOCAL_HIGH);
        n_s1.link_db = (i_dest_b_high == LINK_LOCAL_HIGH);
        n_s1.match_a = n_s1.link_da == (i_src_a_high == LINK_LOCAL_HIGH);
        n_s1.match_b = n_s1.link_db == (i_src_b_high == LINK_LOCAL_HIGH);
        n_s1.flags_a = i_flags_a;
        n_s1.flags_b = i_flags_b;
        n_s1.pol_da  = classify(i_dest_a_high, i_dest_a_low);
        n_s1.pol_db  = classify(i_dest_b_high, i_dest_b_low);
        n_s1.pol_sa  = classify(i_src_a_high, i_src_a_low);
        n_s1.pol_sb  = classify(i_src_b_high, i_src_b_low);
        n_s1.diff_a  = {i_src_a_high, i_src_a_low} ^ {i_dest_a_high, i_dest_a_low};
        n_s1.diff_b  = {i_src_b_high, i_src_b_low} ^ {i_dest_b_high, i_dest_b_low};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
    end

    assign o_valid = r_valid;
    assign o_s1    = r_s1;

endmodule

`default_nettype wire

// File: hw/rtl/ipv6dac_mid.sv
`default_nettype none

module ipv6dac_mid
    import ipv6dac_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire t_s1        i_s1,
    input  wire logic [7:0] i_map_prec,
    output logic            o_valid,
    output t_s2             o_s2
);

    logic r_valid;
    t_s2  r_s2;
    t_s2  n_s2;

    always_comb begin
        n_s2.match_a    = i_s1.match_a;
        n_s2.match_b    = i_s1.match_b;
        n_s2.link_da    = i_s1.link_da;
        n_s2.link_db    = i_s1.link_db;
        n_s2.flags_a    = i_s1.flags_a;
        n_s2.flags_b    = i_s1.flags_b;
        n_s2.label_eq_a = (i_s1.pol_sa.label == i_s1.pol_da.label);
        n_s2.label_eq_b = (i_s1.pol_sb.label == i_s1.pol_db.label);
        n_s2.prec_a     = i_s1.pol_da.mapped ? i_map_prec : {2'b00, i_s1.pol_da.prec};
        n_s2.prec_b     = i_s1.pol_db.mapped ? i_map_prec : {2'b00, i_s1.pol_db.prec};
        n_s2.mapped_a   = i_s1.pol_da.mapped;
        n_s2.mapped_b   = i_s1.pol_db.mapped;
        n_s2.cp_a       = lzc128(i_s1.diff_a);
        n_s2.cp_b       = lzc128(i_s1.diff_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2 <= n_s2;
    end

    assign o_valid = r_valid;
    assign o_s2    = r_s2;

endmodule

`default_nettype wire

// File: hw/rtl/ipv6dac_decide.sv
`default_nettype none

module ipv6dac_decide
    import ipv6dac_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_s2   i_s2,
    output logic       o_done,
    output logic [1:0] o_preference
);

    logic       r_done;
    logic [1:0] r_preference;
    logic [1:0] n_preference;
    logic       dep_a;
    logic       dep_b;
    logic       home_a;
    logic       home_b;

    assign dep_a  = i_s2.flags_a[FLAG_DEPRECATED];
    assign dep_b  = i_s2.flags_b[FLAG_DEPRECATED];
    assign home_a = i_s2.flags_a[FLAG_HOME];
    assign home_b = i_s2.flags_b[FLAG_HOME];

    // The first rule that separates the two candidates decides.
    always_comb begin
        if (i_s2.match_a && !i_s2.match_b) begin
            n_preference = PREF_A;
        end else if (!i_s2.match_a && i_s2.match_b) begin
            n_preference = PREF_B;
        end else if (!dep_a && dep_b) begin
            n_preference = PREF_A;
        end else if (dep_a && !dep_b) begin
            n_preference = PREF_B;
        end else if (home_a && !home_b) begin
            n_preference = PREF_A;
        end else if (!home_a && home_b) begin
            n_preference = PREF_B;
        end else if (!i_s2.flags_a[FLAG_PRESENT]) begin
            // A missing source on A loses even when B lacks one too.
            n_preference = PREF_B;
        end else if (!i_s2.flags_b[FLAG_PRESENT]) begin
            n_preference = PREF_A;
        end else if (i_s2.label_eq_a && !i_s2.label_eq_b) begin
            n_preference = PREF_A;
        end else if (!i_s2.label_eq_a && i_s2.label_eq_b) begin
            n_preference = PREF_B;
        end else if (i_s2.prec_a > i_s2.prec_b) begin
            n_preference = PREF_A;
        end else if (i_s2.prec_a < i_s2.prec_b) begin
            n_preference = PREF_B;
        end else if (i_s2.mapped_a && !i_s2.mapped_b) begin
            n_preference = PREF_B;
        end else if (!i_s2.mapped_a && i_s2.mapped_b) begin
            n_preference = PREF_A;
        end else if (i_s2.link_da && !i_s2.link_db) begin
            n_preference = PREF_A;
        end else if (!i_s2.link_da && i_s2.link_db) begin
            n_preference = PREF_B;
        end else if (i_s2.cp_a > i_s2.cp_b) begin
            n_preference = PREF_A;
        end else if (i_s2.cp_a < i_s2.cp_b) begin
            n_preference = PREF_B;
        end else begin
            n_preference = PREF_EQUAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_preference <= n_preference;
    end

    assign o_done       = r_done;
    assign o_preference = r_preference;

endmodule

`default_nettype wire

// File: hw/rtl/ipv6_destination_address_compare_core.sv
// Channel   Direction  Ports                                     Word
// -------   ---------  ----------------------------------------  -------------------------
// command   in         start / busy                              i_dest_*, i_src_*, i_flags_*
// result    out        o_done (one-cycle strobe)                 o_preference
// config    in         i_cfg_valid / o_cfg_ready                 i_cfg_data (mapped v4 prec)
//
// One word is taken every cycle; busy never rises and o_cfg_ready is always high.
// The pipeline stages are address classify and XOR, common prefix count, and rule chain, each registered.
// Synchronous active-low reset clears the stage valid bits and sets the mapped IPv4
// precedence to 35. The receiver cannot stall; each result appears for one cycle only.

`default_nettype none

module ipv6_destination_address_compare_core
    import ipv6dac_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [63:0] i_dest_a_high,
    input  wire logic [63:0] i_dest_a_low,
    input  wire logic [63:0] i_src_a_high,
    input  wire logic [63:0] i_src_a_low,
    input  wire logic [2:0]  i_flags_a,
    input  wire logic [63:0] i_dest_b_high,
    input  wire logic [63:0] i_dest_b_low,
    input  wire logic [63:0] i_src_b_high,
    input  wire logic [63:0] i_src_b_low,
    input  wire logic [2:0]  i_flags_b,
    output logic             o_done,
    output logic [1:0]       o_preference,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data
);

    logic       r_map_prec_valid;
    logic [7:0] r_map_prec;
    logic       accept;
    logic       s1_valid;
    t_s1        s1;
    logic       s2_valid;
    t_s2        s2;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_prec       <= MAP_PREC_RESET;
            r_map_prec_valid <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_map_prec       <= i_cfg_data;
            r_map_prec_valid <= 1'b1;
        end
    end

    ipv6dac_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (accept),
        .i_dest_a_high (i_dest_a_high),
        .i_dest_a_low  (i_dest_a_low),
        .i_src_a_high  (i_src_a_high),
        .i_src_a_low   (i_src_a_low),
        .i_flags_a     (i_flags_a),
        .i_dest_b_high (i_dest_b_high),
        .i_dest_b_low  (i_dest_b_low),
        .i_src_b_high  (i_src_b_high),
        .i_src_b_low   (i_src_b_low),
        .i_flags_b     (i_flags_b),
        .o_valid       (s1_valid),
        .o_s1          (s1)
    );

    ipv6dac_mid u_mid (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s1_valid),
        .i_s1       (s1),
        .i_map_prec (r_map_prec),
        .o_valid    (s2_valid),
        .o_s2       (s2)
    );

    ipv6dac_decide u_decide (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s2_valid),
        .i_s2         (s2),
        .o_done       (o_done),
        .o_preference (o_preference)
    );

    // Every accepted word produces exactly one result once it has passed the front, mid and decide registers.
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##3 o_done)
        else $error("accepted word did not produce a result");

    a_no_spurious : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, 3))
        else $error("result without a matching accepted word");

    a_code_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_preference == PREF_A || o_preference == PREF_EQUAL ||
                    o_preference == PREF_B))
        else $error("illegal preference code");

    a_prec_reset : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_map_prec_valid |-> r_map_prec == MAP_PREC_RESET)
        else $error("mapped precedence changed without a write");

endmodule

`default_nettype wire

// File: tb/tb_ipv6_destination_address_compare_core.sv
`timescale 1ns / 100ps

module tb_ipv6_destination_address_compare_core;

    import ipv6dac_pkg::*;

    localparam int CYCLE_LIMIT      = 100000;
    localparam int RANDOM_PER_PHASE = 122;
    localparam int POLICY_ROWS      = 9;
    localparam int DRAIN_CYCLES     = 8;
    localparam int GAP_PERCENT      = 26;

    localparam logic [2:0] SRC_OK   = 3'(1 << FLAG_PRESENT);
    localparam logic [2:0] SRC_DEPR = 3'(1 << FLAG_DEPRECATED);
    localparam logic [2:0] SRC_HOME = 3'(1 << FLAG_HOME);

    typedef struct packed {
        logic [127:0] dest_a;
        logic [127:0] src_a;
        logic [2:0]   flags_a;
        logic [127:0] dest_b;
        logic [127:0] src_b;
        logic [2:0]   flags_b;
    } t_dest_pair;

    typedef struct packed {
        logic [127:0] prefix;
        logic [7:0]   len;
        logic [7:0]   prec;
        logic [3:0]   label;
        logic         mapped;
    } t_policy_row;

    typedef enum int {
        CLS_LOOPBACK, CLS_UNSPEC, CLS_MAPPED, CLS_COMPAT, CLS_6TO4, CLS_TEREDO,
        CLS_ULA, CLS_SITE, CLS_6BONE, CLS_LINK, CLS_GLOBAL, CLS_COUNT
    } t_addr_class;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [7:0] cfg_data = 8'd0;
    t_dest_pair pair_on_bus = '0;
    wire        busy;
    wire        o_done;
    wire [1:0]  o_preference;
    wire        o_cfg_ready;

    t_dest_pair pair_backlog[$];
    logic [1:0] pref_expected[$];
    logic [7:0] map_prec_model = MAP_PREC_RESET;
    bit         gapless = 1'b0;
    int         mismatch_count = 0;
    int         cycle_count = 0;

    ipv6_destination_address_compare_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_dest_a_high (pair_on_bus.dest_a[127:64]),
        .i_dest_a_low  (pair_on_bus.dest_a[63:0]),
        .i_src_a_high  (pair_on_bus.src_a[127:64]),
        .i_src_a_low   (pair_on_bus.src_a[63:0]),
        .i_flags_a     (pair_on_bus.flags_a),
        .i_dest_b_high (pair_on_bus.dest_b[127:64]),
        .i_dest_b_low  (pair_on_bus.dest_b[63:0]),
        .i_src_b_high  (pair_on_bus.src_b[127:64]),
        .i_src_b_low   (pair_on_bus.src_b[63:0]),
        .i_flags_b     (pair_on_bus.flags_b),
        .o_done        (o_done),
        .o_preference  (o_preference),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Default policy table; rows may be searched in any order since the longest match wins.
    function automatic t_policy_row policy_row_at(input int idx);
        t_policy_row row;
        case (idx)
            0:       row = '{128'd1, 8'd128, 8'd50, 4'd0, 1'b0};
            1:       row = '{128'd0, 8'd0, 8'd40, 4'd1, 1'b0};
            2:       row = '{{80'd0, 16'hffff, 32'd0}, 8'd96, 8'd0, 4'd4, 1'b1};
            3:       row = '{{16'h2002, 112'd0}, 8'd16, 8'd30, 4'd2, 1'b0};
            4:       row = '{{32'h2001_0000, 96'd0}, 8'd32, 8'd5, 4'd5, 1'b0};
            5:       row = '{{16'hfc00, 112'd0}, 8'd7, 8'd3, 4'd13, 1'b0};
            6:       row = '{128'd0, 8'd96, 8'd1, 4'd3, 1'b0};
            7:       row = '{{16'hfec0, 112'd0}, 8'd10, 8'd1, 4'd11, 1'b0};
            default: row = '{{16'h3ffe, 112'd0}, 8'd16, 8'd1, 4'd12, 1'b0};
        endcase
        return row;
    endfunction

    function automatic void policy_lookup(input logic [127:0] addr, input logic [7:0] map_prec,
                                          output logic [7:0] prec, output logic [3:0] label,
                                          output logic mapped);
        t_policy_row row;
        t_policy_row best;
        logic [127:0] mask;
        best = policy_row_at(1);
        for (int i = 0; i < POLICY_ROWS; i++) begin
            row = policy_row_at(i);
            mask = (row.len == 8'd0) ? '0 : ~128'd0 << (128 - row.len);
            if (((addr ^ row.prefix) & mask) == '0 && row.len > best.len) begin
                best = row;
            end
        end
        prec = best.mapped ? map_prec : best.prec;
        label = best.label;
        mapped = best.mapped;
    endfunction

    function automatic int common_len(input logic [127:0] x, input logic [127:0] y);
        logic [127:0] d;
        int n;
        d = x ^ y;
        n = 0;
        while (n < 128 && !d[127 - n]) n++;
        return n;
    endfunction

    // Destination ordering rules, first rule that separates the pair decides.
    function automatic logic [1:0] prefer_dest(input t_dest_pair c, input logic [7:0] map_prec);
        logic link_da, link_db, match_a, match_b;
        logic dep_a, dep_b, home_a, home_b;
        logic [7:0] pda, pdb, psa, psb;
        logic [3:0] lda, ldb, lsa, lsb;
        logic mda, mdb, msa, msb;
        int cpa, cpb;
        link_da = c.dest_a[127:64] == LINK_LOCAL_HIGH;
        link_db = c.dest_b[127:64] == LINK_LOCAL_HIGH;
        match_a = link_da == (c.src_a[127:64] == LINK_LOCAL_HIGH);
        match_b = link_db == (c.src_b[127:64] == LINK_LOCAL_HIGH);
        dep_a = c.flags_a[FLAG_DEPRECATED];
        dep_b = c.flags_b[FLAG_DEPRECATED];
        home_a = c.flags_a[FLAG_HOME];
        home_b = c.flags_b[FLAG_HOME];
        if (match_a != match_b) return match_a ? PREF_A : PREF_B;
        if (dep_a != dep_b) return dep_b ? PREF_A : PREF_B;
        if (home_a != home_b) return home_a ? PREF_A : PREF_B;
        // A missing source on A loses even when B has none either.
        if (!c.flags_a[FLAG_PRESENT]) return PREF_B;
        if (!c.flags_b[FLAG_PRESENT]) return PREF_A;
        policy_lookup(c.dest_a, map_prec, pda, lda, mda);
        policy_lookup(c.dest_b, map_prec, pdb, ldb, mdb);
        policy_lookup(c.src_a, map_prec, psa, lsa, msa);
        policy_lookup(c.src_b, map_prec, psb, lsb, msb);
        if ((lsa == lda) != (lsb == ldb)) return (lsa == lda) ? PREF_A : PREF_B;
        if (pda != pdb) return (pda > pdb) ? PREF_A : PREF_B;
        if (mda != mdb) return mdb ? PREF_A : PREF_B;
        if (link_da != link_db) return link_da ? PREF_A : PREF_B;
        cpa = common_len(c.src_a, c.dest_a);
        cpb = common_len(c.src_b, c.dest_b);
        if (cpa != cpb) return (cpa > cpb) ? PREF_A : PREF_B;
        return PREF_EQUAL;
    endfunction

    function automatic logic [127:0] pick_addr(input t_addr_class cls);
        logic [127:0] r;
        logic [127:0] a;
        r = {$urandom, $urandom, $urandom, $urandom};
        case (cls)
            CLS_LOOPBACK: a = 128'd1;
            CLS_UNSPEC:   a = 128'd0;
            CLS_MAPPED:   a = {80'd0, 16'hffff, r[31:0]};
            CLS_COMPAT:   a = {96'd0, r[31:0]};
            CLS_6TO4:     a = {16'h2002, r[111:0]};
            CLS_TEREDO:   a = {32'h2001_0000, r[95:0]};
            CLS_ULA:      a = {7'b1111110, r[120:0]};
            CLS_SITE:     a = {10'b1111111011, r[117:0]};
            CLS_6BONE:    a = {16'h3ffe, r[111:0]};
            CLS_LINK:     a = {LINK_LOCAL_HIGH, r[63:0]};
            default:      a = r;
        endcase
        // Now and then flip one random bit, which may carry the address out of its prefix.
        if ($urandom_range(9) == 0) a = a ^ (128'd1 << $urandom_range(127));
        return a;
    endfunction

    // Mostly a source that shares exactly k leading bits with its destination.
    function automatic logic [127:0] pick_source(input logic [127:0] dest);
        logic [127:0] r, keep, flip, s;
        int k;
        if ($urandom_range(99) < 35) return pick_addr(t_addr_class'($urandom_range(CLS_COUNT - 1)));
        k = $urandom_range(128);
        if (k == 128) return dest;
        r = {$urandom, $urandom, $urandom, $urandom};
        keep = ~(~128'd0 >> k);
        flip = 128'd1 << (127 - k);
        s = (dest & keep) | (r & ~keep);
        s = (s & ~flip) | (~dest & flip);
        return s;
    endfunction

    function automatic t_dest_pair random_pair();
        t_dest_pair p;
        logic [2:0] shared;
        p.dest_a = pick_addr(t_addr_class'($urandom_range(CLS_COUNT - 1)));
        p.src_a = pick_source(p.dest_a);
        p.dest_b = pick_addr(t_addr_class'($urandom_range(CLS_COUNT - 1)));
        p.src_b = pick_source(p.dest_b);
        if ($urandom_range(99) < 70) begin
            shared = 3'($urandom_range(7)) | SRC_OK;
            p.flags_a = shared;
            p.flags_b = shared;
            if ($urandom_range(3) == 0) p.flags_b = shared ^ 3'(1 << $urandom_range(2));
        end else begin
            p.flags_a = 3'($urandom_range(7));
            p.flags_b = 3'($urandom_range(7));
        end
        if ($urandom_range(99) < 8) begin
            p.dest_b = p.dest_a;
            p.src_b = p.src_a;
            p.flags_b = p.flags_a;
        end
        return p;
    endfunction

    task automatic push_pair(input logic [127:0] da, input logic [127:0] sa, input logic [2:0] fa,
                             input logic [127:0] db, input logic [127:0] sb, input logic [2:0] fb);
        pair_backlog.push_back('{da, sa, fa, db, sb, fb});
    endtask

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%s", msg);
    endtask

    // Sampled at the falling edge so the driver's updates of the rising edge have settled.
    task automatic wait_quiet();
        while (pair_backlog.size() != 0 || start || pref_expected.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_map_prec(input logic [7:0] value);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        map_prec_model = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random_phase(input logic [7:0] prec, input bit no_gaps);
        wait_quiet();
        write_map_prec(prec);
        gapless = no_gaps;
        repeat (RANDOM_PER_PHASE) pair_backlog.push_back(random_pair());
    endtask

    // Command driver: a word is taken at an edge where start is high and busy is low.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                pref_expected.push_back(prefer_dest(pair_on_bus, map_prec_model));
            end
            if (!start || !busy) begin
                if (pair_backlog.size() != 0 &&
                    (gapless || $urandom_range(99) >= GAP_PERCENT)) begin
                    pair_on_bus <= pair_backlog.pop_front();
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        logic [1:0] want;
        if (i_rst_n && o_done) begin
            if (pref_expected.size() == 0) begin
                log_mismatch($sformatf("result %0d with nothing expected", o_preference));
            end else begin
                want = pref_expected.pop_front();
                if (o_preference !== want) begin
                    log_mismatch($sformatf("preference mismatch: expected %0d, got %0d",
                                           want, o_preference));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        logic [127:0] gua_a, gua_b, ll_a;
        gua_a = 128'h2a00_1450_4001_0800_0000_0000_0000_200e;
        gua_b = 128'h2400_cb00_2048_0001_0000_0000_6810_0001;
        ll_a = {LINK_LOCAL_HIGH, 64'h0211_22ff_fe33_4455};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pairs run at the reset value of the mapped IPv4 precedence.
        push_pair('0, '0, 3'd0, '0, '0, 3'd0);
        push_pair(~128'd0, ~128'd0, 3'h7, ~128'd0, ~128'd0, 3'h7);
        push_pair(ll_a, gua_a, SRC_OK, gua_b, gua_b ^ 128'd1, SRC_OK);
        push_pair(gua_a, gua_a, SRC_OK, ll_a, gua_b, SRC_OK);
        push_pair(gua_a, gua_a, SRC_OK | SRC_DEPR, gua_b, gua_b, SRC_OK);
        push_pair(gua_a, gua_a, SRC_OK, gua_b, gua_b, SRC_OK | SRC_HOME);
        push_pair(gua_a, gua_a, 3'd0, gua_b, gua_b, SRC_OK);
        push_pair(gua_a, gua_a, 3'd0, gua_b, gua_b, 3'd0);
        push_pair(gua_a, gua_a, SRC_OK, gua_b, gua_b, 3'd0);
        push_pair({16'h2002, 112'h1}, {16'h2002, 112'h2}, SRC_OK,
                  {16'h2002, 112'h3}, gua_b, SRC_OK);
        push_pair(128'd1, 128'd1, SRC_OK, gua_b, gua_b, SRC_OK);
        push_pair({16'hfc00, 112'h1}, {16'hfd00, 112'h2}, SRC_OK,
                  {16'h2002, 112'h5}, {16'h2002, 112'h6}, SRC_OK);
        push_pair({80'd0, 16'hffff, 32'hc0a8_0001}, {80'd0, 16'hffff, 32'hc0a8_0002}, SRC_OK,
                  {80'd0, 16'hffff, 32'h0a00_0001}, {80'd0, 16'hffff, 32'h0b00_0001}, SRC_OK);
        push_pair({32'h2001_0000, 96'h7}, {32'h2001_0000, 96'h8}, SRC_OK,
                  {16'h3ffe, 112'h9}, {16'h3ffe, 112'ha}, SRC_OK);
        push_pair({16'hfec0, 112'h1}, {16'hfec0, 112'hff}, SRC_OK,
                  {96'd0, 32'h0102_0304}, {96'd0, 32'h0102_0305}, SRC_OK);
        push_pair(ll_a, ll_a ^ 128'h3, SRC_OK, gua_b, gua_b ^ 128'h3, SRC_OK);
        push_pair(gua_a, gua_a ^ 128'd1, SRC_OK, gua_b, gua_b ^ (128'd1 << 117), SRC_OK);
        push_pair(gua_a, gua_a ^ (128'd1 << 100), SRC_OK | SRC_HOME,
                  gua_a, gua_a ^ (128'd1 << 100), SRC_OK | SRC_HOME);
        push_pair(128'd1, 128'd0, SRC_OK, 128'd0, 128'd1, SRC_OK);
        push_pair({64'hfe80_0000_0000_0001, 64'h1}, {64'hfe80_0000_0000_0001, 64'h2}, SRC_OK,
                  {16'hfebf, 112'h1}, {16'hfebf, 112'h2}, SRC_OK);
        push_pair({16'h2001, 16'h0001, 96'h1}, {16'h2001, 16'h0001, 96'h2}, SRC_OK,
                  {16'hfe00, 112'h1}, {16'hfe00, 112'h1}, SRC_OK);
        repeat (RANDOM_PER_PHASE) pair_backlog.push_back(random_pair());

        // Precedence values that tie the mapped class with the native classes at 40, 1, 30 and 50, and the extremes.
        run_random_phase(8'd0, 1'b0);
        run_random_phase(8'd255, 1'b1);
        run_random_phase(8'd100, 1'b0);
        run_random_phase(8'd40, 1'b0);
        run_random_phase(8'd1, 1'b0);
        run_random_phase(8'd30, 1'b0);
        run_random_phase(8'($urandom_range(255)), 1'b0);
        run_random_phase(8'd50, 1'b0);

        wait_quiet();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pref_expected.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
